// ----- hw/rtl/ofpq_pkg.sv -----
// Shared types and constants for the oldest-first process queue.
// No dependencies; imported by ofpq_store, ofpq_best and oldest_first_process_queue.
package ofpq_pkg;

	localparam int ID_W    = 32;
	localparam int STAMP_W = 16;
	localparam int ENTRY_W = ID_W + STAMP_W;

	localparam logic [STAMP_W-1:0] STAMP_RESET = 16'd100;

	// command codes (s_tuser)
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LIST   = 2'd2;

	// status codes (m_tuser)
	localparam logic [2:0] ST_INSERTED   = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_REMOVED    = 3'd2;
	localparam logic [2:0] ST_EMPTY      = 3'd3;
	localparam logic [2:0] ST_LISTED     = 3'd4;
	localparam logic [2:0] ST_LIST_EMPTY = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_REPLY,
		S_LIST
	} state_t;

	// control from the sequencer to the compare unit
	typedef struct packed {
		logic valid;   // a stored entry is on the read port
		logic first;   // it is entry 0: load unconditionally
	} best_ctl_t;

endpackage

// ----- hw/rtl/oldest_first_process_queue.sv -----
// Oldest-first process queue, top level: sequencer, counters and output register.
// Depends on ofpq_pkg, ofpq_store and ofpq_best.
//
//  - s_* channel takes one command per transaction: s_tuser = command,
//    s_tdata = proc_id (used by insert only).
//  - m_* channel returns results: m_tuser = status, m_tdata = {out_stamp, out_id},
//    m_tlast marks the final result of a command.
//  - cfg_* writes stamp_start and reloads the stamp down-counter at once; always ready.
//    Write it only while no command is in flight.
//  - One command at a time; s_tready is high only when the sequencer is idle.
//    Work per command, with N entries stored:
//      insert / full / empty cases : answered from the exec state
//      remove                      : scan all N entries through the shared
//                                    comparator, then shift the tail down one place
//      list                        : one entry per cycle while m_tready holds
//  - Results sit in an output register; a new command may be accepted while the
//    last result waits, and the sequencer stalls only when it must emit again.
//  - m_tready low stalls the sequencer in place; nothing is dropped.
//  - Reset (arst_n low) empties the queue and sets the stamp counter to 100.
//    Stored entries are not cleared; only positions below the count are read.
module oldest_first_process_queue
	import ofpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // [31:0] proc_id
	input  logic [1:0]         s_tuser,   // [1:0] command
	// result channel
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,   // [31:0] out_id, [47:32] out_stamp
	output logic [2:0]         m_tuser,   // [2:0] status
	output logic               m_tlast,
	// configuration: stamp_start
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;

	logic [1:0]         cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      ptr_q;
	logic [AW-1:0]      ridx_q;
	logic               rv_q;
	logic [STAMP_W-1:0] next_stamp_q;

	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic [ID_W-1:0]    out_id_q;
	logic [STAMP_W-1:0] out_stamp_q;
	logic               out_last_q;

	// memory and comparator hookup
	logic               we, re;
	logic [AW-1:0]      waddr;
	logic [ENTRY_W-1:0] wdata, rdata;
	logic [AW-1:0]      best_idx;
	logic [ENTRY_W-1:0] best_entry;
	best_ctl_t          best_ctl;

	// sequencer controls
	logic               accept, out_free, cnt_empty, cnt_full, ptr_live;
	logic               out_load, cnt_inc, cnt_dec, stamp_dec, ptr_load, rv_clr;
	logic               list_last;
	logic [2:0]         out_status_d;
	logic [ID_W-1:0]    out_id_d;
	logic [STAMP_W-1:0] out_stamp_d;
	logic               out_last_d;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign cnt_empty = (cnt_q == '0);
	assign cnt_full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign ptr_live  = (ptr_q < cnt_q);
	assign list_last = ((CW'(ridx_q) + CW'(1)) == cnt_q);

	ofpq_store #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	ofpq_best #(
		.AW (AW)
	) u_best (
		.clk        (clk),
		.ctl        (best_ctl),
		.idx        (ridx_q),
		.entry      (rdata),
		.best_idx   (best_idx),
		.best_entry (best_entry)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_INSERT: begin
						if (out_free) state_d = S_IDLE;
					end
					CMD_REMOVE: begin
						if (!cnt_empty) state_d = S_SCAN;
						else if (out_free) state_d = S_IDLE;
					end
					CMD_LIST: begin
						if (!cnt_empty) state_d = S_LIST;
						else if (out_free) state_d = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				if (!ptr_live && !rv_q) state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (!ptr_live && !rv_q) state_d = S_REPLY;
			end
			S_REPLY: begin
				if (out_free) state_d = S_IDLE;
			end
			S_LIST: begin
				if (rv_q && out_free && list_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready     = (state_q == S_IDLE);
		we           = 1'b0;
		waddr        = cnt_q[AW-1:0];
		wdata        = {next_stamp_q, id_q};
		re           = 1'b0;
		best_ctl     = '0;
		out_load     = 1'b0;
		out_status_d = ST_INSERTED;
		out_id_d     = '0;
		out_stamp_d  = '0;
		out_last_d   = 1'b1;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		stamp_dec    = 1'b0;
		ptr_load     = 1'b0;
		rv_clr       = 1'b0;
		case (state_q)
			S_IDLE: begin
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_INSERT: begin
						if (out_free) begin
							out_load = 1'b1;
							if (cnt_full) begin
								out_status_d = ST_FULL;
							end else begin
								we           = 1'b1;
								cnt_inc      = 1'b1;
								stamp_dec    = (next_stamp_q != '0);
								out_status_d = ST_INSERTED;
								out_id_d     = id_q;
								out_stamp_d  = next_stamp_q;
							end
						end
					end
					CMD_REMOVE: begin
						if (cnt_empty && out_free) begin
							out_load     = 1'b1;
							out_status_d = ST_EMPTY;
						end
					end
					CMD_LIST: begin
						if (cnt_empty && out_free) begin
							out_load     = 1'b1;
							out_status_d = ST_LIST_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				re             = ptr_live;
				rv_clr         = 1'b1;
				best_ctl.valid = rv_q;
				best_ctl.first = (ridx_q == '0);
				ptr_load       = !ptr_live && !rv_q;
			end
			S_SHIFT: begin
				// entry read last cycle moves down one place
				re     = ptr_live;
				rv_clr = 1'b1;
				we     = rv_q;
				waddr  = ridx_q - AW'(1);
				wdata  = rdata;
				cnt_dec = !ptr_live && !rv_q;
			end
			S_REPLY: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = ST_REMOVED;
					out_id_d     = best_entry[ID_W-1:0];
					out_stamp_d  = best_entry[ENTRY_W-1:ID_W];
				end
			end
			S_LIST: begin
				re = ptr_live && (!rv_q || out_free);
				if (rv_q && out_free) begin
					out_load     = 1'b1;
					rv_clr       = 1'b1;
					out_status_d = ST_LISTED;
					out_id_d     = rdata[ID_W-1:0];
					out_stamp_d  = rdata[ENTRY_W-1:ID_W];
					out_last_d   = list_last;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ptr_q        <= '0;
			rv_q         <= 1'b0;
			next_stamp_q <= STAMP_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) cnt_q <= cnt_q + CW'(1);
			else if (cnt_dec) cnt_q <= cnt_q - CW'(1);
			if (accept) ptr_q <= '0;
			else if (ptr_load) ptr_q <= CW'(best_idx) + CW'(1);
			else if (re) ptr_q <= ptr_q + CW'(1);
			if (accept) rv_q <= 1'b0;
			else if (re) rv_q <= 1'b1;
			else if (rv_clr) rv_q <= 1'b0;
			if (cfg_valid) next_stamp_q <= cfg_data;
			else if (stamp_dec) next_stamp_q <= next_stamp_q - STAMP_W'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tuser;
			id_q  <= s_tdata;
		end
		if (re) ridx_q <= ptr_q[AW-1:0];
		if (out_load) begin
			out_status_q <= out_status_d;
			out_id_q     <= out_id_d;
			out_stamp_q  <= out_stamp_d;
			out_last_q   <= out_last_d;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {out_stamp_q, out_id_q};
	assign m_tuser   = out_status_q;
	assign m_tlast   = out_last_q;

endmodule

// ----- hw/rtl/ofpq_store.sv -----
// Entry storage: one write port, one read port with registered read data.
// Depends on ofpq_pkg for the entry width.
module ofpq_store
	import ofpq_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem_q [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/ofpq_best.sv -----
// Shared stamp comparator: keeps the running best (largest stamp, lowest index).
// Depends on ofpq_pkg for widths and the control struct.
module ofpq_best
	import ofpq_pkg::*;
#(
	parameter int AW = 3
) (
	input  logic               clk,
	input  best_ctl_t          ctl,
	input  logic [AW-1:0]      idx,
	input  logic [ENTRY_W-1:0] entry,
	output logic [AW-1:0]      best_idx,
	output logic [ENTRY_W-1:0] best_entry
);

	logic [AW-1:0]      best_idx_q;
	logic [ENTRY_W-1:0] best_entry_q;
	logic               take;

	// strict greater-than keeps the lowest position on a tie
	assign take = ctl.valid &&
		(ctl.first || (entry[ENTRY_W-1:ID_W] > best_entry_q[ENTRY_W-1:ID_W]));

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= idx;
			best_entry_q <= entry;
		end
	end

	assign best_idx   = best_idx_q;
	assign best_entry = best_entry_q;

endmodule
